/* hw/rtl/nv3_pkg.sv */
package nv3_pkg;

    // width of one unit-vector component, signed q1.15
    localparam int UNIT_W = 16;
    // quotient bits found by the lane pipeline
    localparam int QUOT_W = 16;
    // extra comparison headroom above the squared sum
    localparam int CMP_EXTRA = 34;

    localparam logic [UNIT_W-1:0] UNIT_MAX = 16'h7fff;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic              neg;
        logic [QUOT_W-1:0] mag;
    } nv3_lane_res_t;

endpackage

/* hw/rtl/nv3_prep.sv */
module nv3_prep
    import nv3_pkg::*;
#(
    parameter int COMP_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [COMP_WIDTH-1:0]     comp_x,
    input  logic [COMP_WIDTH-1:0]     comp_y,
    input  logic [COMP_WIDTH-1:0]     comp_z,
    output logic [2*COMP_WIDTH-1:0]   sq_x,
    output logic [2*COMP_WIDTH-1:0]   sq_y,
    output logic [2*COMP_WIDTH-1:0]   sq_z,
    output logic [2:0]                neg,
    output logic [2*COMP_WIDTH-1:0]   sum_sq,
    output logic                      zero_len
);

    localparam int W = COMP_WIDTH;

    logic [W-1:0]   mag_x, mag_y, mag_z;
    logic [2*W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [2*W-1:0] sqx2_reg, sqy2_reg, sqz2_reg;
    logic [2:0]     neg_reg, neg2_reg;
    logic [2*W-1:0] sum_reg;
    logic           zero_reg;
    logic [2*W-1:0] sum_next;

    // magnitudes of the two's complement inputs
    assign mag_x = comp_x[W-1] ? (~comp_x + 1'b1) : comp_x;
    assign mag_y = comp_y[W-1] ? (~comp_y + 1'b1) : comp_y;
    assign mag_z = comp_z[W-1] ? (~comp_z + 1'b1) : comp_z;

    // sum of squares stays below 2^(2w)
    assign sum_next = sqx_reg + sqy_reg + sqz_reg;

    // stage one squares, stage two sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg  <= mag_x * mag_x;
            sqy_reg  <= mag_y * mag_y;
            sqz_reg  <= mag_z * mag_z;
            neg_reg  <= {comp_z[W-1], comp_y[W-1], comp_x[W-1]};
            sqx2_reg <= sqx_reg;
            sqy2_reg <= sqy_reg;
            sqz2_reg <= sqz_reg;
            neg2_reg <= neg_reg;
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
        end
    end

    assign sq_x     = sqx2_reg;
    assign sq_y     = sqy2_reg;
    assign sq_z     = sqz2_reg;
    assign neg      = neg2_reg;
    assign sum_sq   = sum_reg;
    assign zero_len = zero_reg;

endmodule

/* hw/rtl/nv3_lane.sv */
module nv3_lane
    import nv3_pkg::*;
#(
    parameter int COMP_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    adv,
    input  logic [2*COMP_WIDTH-1:0] sq_c,
    input  logic [2*COMP_WIDTH-1:0] sum_sq,
    input  logic                    neg,
    output nv3_lane_res_t           res
);

    localparam int SW = 2 * COMP_WIDTH;
    localparam int CW = SW + CMP_EXTRA;

    // per stage: quotient so far, s*q^2, s*q, and the operands carried along
    logic [QUOT_W-1:0] q_reg   [QUOT_W];
    logic [CW-1:0]     a_reg   [QUOT_W];
    logic [CW-1:0]     b_reg   [QUOT_W];
    logic [SW-1:0]     s_reg   [QUOT_W];
    logic [SW-1:0]     c2_reg  [QUOT_W];
    logic              neg_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;

        logic [QUOT_W-1:0] q_in;
        logic [CW-1:0]     a_in, b_in;
        logic [SW-1:0]     s_in, c2_in;
        logic              neg_in;
        logic [CW-1:0]     s_ext, a_try, b_try, lhs, rhs;
        logic              take;

        if (k == 0) begin : g_first
            assign q_in   = '0;
            assign a_in   = '0;
            assign b_in   = '0;
            assign s_in   = sum_sq;
            assign c2_in  = sq_c;
            assign neg_in = neg;
        end else begin : g_next
            assign q_in   = q_reg[k-1];
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign s_in   = s_reg[k-1];
            assign c2_in  = c2_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        // trial t = q + 2^bit: s*t^2 and s*t by shifts and adds
        assign s_ext = {{(CW-SW){1'b0}}, s_in};
        assign a_try = a_in + (b_in << (BIT + 1)) + (s_ext << (2 * BIT));
        assign b_try = b_in + (s_ext << BIT);
        // s*(2t-1)^2 against c^2 * 2^32
        assign lhs   = (a_try << 2) - (b_try << 2) + s_ext;
        assign rhs   = {{(CW-SW){1'b0}}, c2_in} << 32;
        // once q reaches one, no further bit is set
        assign take  = (lhs <= rhs) && !q_in[QUOT_W-1];

        always_ff @(posedge aclk) begin
            if (adv) begin
                q_reg[k]   <= take ? (q_in | (QUOT_W'(1) << BIT)) : q_in;
                a_reg[k]   <= take ? a_try : a_in;
                b_reg[k]   <= take ? b_try : b_in;
                s_reg[k]   <= s_in;
                c2_reg[k]  <= c2_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign res.neg = neg_reg[QUOT_W-1];
    assign res.mag = q_reg[QUOT_W-1];

endmodule

/* hw/rtl/nv3_merge.sv */
module nv3_merge
    import nv3_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic            zero_len,
    input  nv3_lane_res_t   res_x,
    input  nv3_lane_res_t   res_y,
    input  nv3_lane_res_t   res_z,
    output logic            out_valid,
    output logic [3*UNIT_W-1:0] out_data,
    output logic            out_zero
);

    logic                    valid_reg;
    logic [3*UNIT_W-1:0]     data_reg;
    logic                    zero_reg;
    logic [UNIT_W-1:0]       ux, uy, uz;

    // signed q1.15 with +1.0 saturated
    function automatic logic [UNIT_W-1:0] to_q15(nv3_lane_res_t r, logic zl);
        logic [UNIT_W-1:0] v;
        if (zl) begin
            v = '0;
        end else if (r.neg) begin
            v = UNIT_W'(~r.mag + 1'b1);
        end else if (r.mag[QUOT_W-1]) begin
            v = UNIT_MAX;
        end else begin
            v = UNIT_W'(r.mag);
        end
        return v;
    endfunction

    assign ux = to_q15(res_x, zero_len);
    assign uy = to_q15(res_y, zero_len);
    assign uz = to_q15(res_z, zero_len);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= {uz, uy, ux};
            zero_reg <= zero_len;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;

endmodule

/* hw/rtl/normalize_vector_3d.sv */
// channel | dir | tdata fields (low to high)     | tuser
// s_      | in  | comp_x, comp_y, comp_z          | -
// m_      | out | unit_x, unit_y, unit_z (16 each)| zero_length
//
// one beat per cycle unless m_ stalls; stages: squares, sum, 16 quotient
// stages (one quotient bit per stage in each of three lanes), output register
// reset clears only the valid bits of the pipeline
// a stall on m_ freezes the whole pipeline; s_tready follows m_tready then
module normalize_vector_3d
    import nv3_pkg::*;
#(
    parameter int COMP_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // comp_x, comp_y, comp_z, zero pad
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // unit_x, unit_y, unit_z
    output logic [3*UNIT_W-1:0]                 m_tdata,
    // zero_length
    output logic                                m_tuser
);

    localparam int W     = COMP_WIDTH;
    localparam int DEPTH = 2 + QUOT_W;

    logic                adv;
    logic [2*W-1:0]      sq_x, sq_y, sq_z, sum_sq;
    logic [2:0]          neg;
    logic                zero_len;
    nv3_lane_res_t       res_x, res_y, res_z;
    logic [DEPTH-1:0]    vld_reg;
    logic [QUOT_W-1:0]   zl_reg;

    // pipeline moves when the output register is free
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // valid and zero flag delay lines
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
        if (adv) begin
            zl_reg <= {zl_reg[QUOT_W-2:0], zero_len};
        end
    end

    nv3_prep #(.COMP_WIDTH(W)) u_prep (
        .aclk     (aclk),
        .adv      (adv),
        .comp_x   (s_tdata[W-1:0]),
        .comp_y   (s_tdata[2*W-1:W]),
        .comp_z   (s_tdata[3*W-1:2*W]),
        .sq_x     (sq_x),
        .sq_y     (sq_y),
        .sq_z     (sq_z),
        .neg      (neg),
        .sum_sq   (sum_sq),
        .zero_len (zero_len)
    );

    nv3_lane #(.COMP_WIDTH(W)) u_lane_x (
        .aclk (aclk), .adv (adv), .sq_c (sq_x), .sum_sq (sum_sq), .neg (neg[0]),
        .res  (res_x)
    );

    nv3_lane #(.COMP_WIDTH(W)) u_lane_y (
        .aclk (aclk), .adv (adv), .sq_c (sq_y), .sum_sq (sum_sq), .neg (neg[1]),
        .res  (res_y)
    );

    nv3_lane #(.COMP_WIDTH(W)) u_lane_z (
        .aclk (aclk), .adv (adv), .sq_c (sq_z), .sum_sq (sum_sq), .neg (neg[2]),
        .res  (res_z)
    );

    nv3_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld_reg[DEPTH-1]),
        .zero_len  (zl_reg[QUOT_W-1]),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_zero  (m_tuser)
    );

    // zero vector gives zero components
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector with nonzero components");

    // a nonzero vector has at least one nonzero unit component
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("nonzero vector normalized to all zeros");

    // stalled pipeline keeps its occupancy
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline occupancy changed during stall");

endmodule

/* test/normalize_vector_3d_tb.sv */
module normalize_vector_3d_tb;
    import nv3_pkg::*;

    localparam int CW = 16;
    localparam int DW = ((3*CW+7)/8)*8;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic        zl;
    } unit_vec_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [DW-1:0]   s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [3*UNIT_W-1:0] m_tdata;
    logic            m_tuser;

    logic [DW-1:0] vec_queue[$];
    unit_vec_t     unit_queue[$];
    int            err_count = 0;
    int            n_sent = 0;
    int            n_got = 0;
    int            n_zero = 0;
    bit            no_idle = 1'b0;

    normalize_vector_3d #(.COMP_WIDTH(CW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // rounded |c| * 2^15 / sqrt(s), bit by bit with exact squares
    function automatic logic [16:0] scaled_mag(input logic [15:0] c, input logic [33:0] s);
        logic [16:0]  q;
        logic [16:0]  t;
        logic [33:0]  odd;
        logic [127:0] lhs;
        logic [127:0] rhs;
        q = '0;
        rhs = 128'(c) * 128'(c) << 32;
        for (int b = 15; b >= 0; b--) begin
            t = q | (17'd1 << b);
            if (t <= 17'd32768) begin
                odd = 2 * 34'(t) - 1;
                lhs = 128'(s) * 128'(odd) * 128'(odd);
                if (lhs <= rhs) q = t;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] to_unit(input logic [15:0] c, input logic neg,
                                            input logic [33:0] s);
        logic [16:0] q;
        q = scaled_mag(c, s);
        if (neg) return 16'(17'h10000 - q);
        if (q > 17'd32767) return UNIT_MAX;
        return q[15:0];
    endfunction

    function automatic unit_vec_t normalize(input logic [DW-1:0] d);
        logic signed [15:0] c[3];
        logic [15:0] a[3];
        logic [33:0] s;
        unit_vec_t r;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            c[i] = d[16*i +: 16];
            a[i] = c[i][15] ? 16'(-c[i]) : c[i];
            s += 34'(a[i]) * 34'(a[i]);
        end
        if (s == 0) return '{16'd0, 16'd0, 16'd0, 1'b1};
        r.ux = to_unit(a[0], c[0][15], s);
        r.uy = to_unit(a[1], c[1][15], s);
        r.uz = to_unit(a[2], c[2][15], s);
        r.zl = 1'b0;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at beat %0d: %s got %h want %h", n_got, what, got, want);
        err_count++;
    endtask

    function automatic logic [DW-1:0] pack_vec(input logic [15:0] x, input logic [15:0] y,
                                               input logic [15:0] z);
        return DW'({z, y, x});
    endfunction

    // driver: present pending vectors, idle at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                unit_queue.push_back(normalize(s_tdata));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (vec_queue.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
                    s_tdata  <= vec_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat, stall at random
    always @(posedge aclk) begin
        unit_vec_t exp_u;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (unit_queue.size() == 0) begin
                    report("unexpected beat", m_tdata[31:0], 0);
                end else begin
                    exp_u = unit_queue.pop_front();
                    if (m_tdata[15:0] !== exp_u.ux) report("unit_x", m_tdata[15:0], exp_u.ux);
                    if (m_tdata[31:16] !== exp_u.uy) report("unit_y", m_tdata[31:16], exp_u.uy);
                    if (m_tdata[47:32] !== exp_u.uz) report("unit_z", m_tdata[47:32], exp_u.uz);
                    if (m_tuser !== exp_u.zl) report("zero_length", m_tuser, exp_u.zl);
                    if (exp_u.zl) n_zero++;
                end
                n_got++;
            end
            m_tready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    // stimulus
    initial begin
        logic [15:0] v[3];
        logic [15:0] edges[7];
        edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h8001, 16'h5555};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: zero vector, plus and minus one, extremes
        vec_queue.push_back(pack_vec(0, 0, 0));
        vec_queue.push_back(pack_vec(16'h7fff, 0, 0));
        vec_queue.push_back(pack_vec(0, 16'h8000, 0));
        vec_queue.push_back(pack_vec(0, 0, 16'h0001));
        vec_queue.push_back(pack_vec(0, 0, 16'hffff));
        vec_queue.push_back(pack_vec(16'h8000, 16'h8000, 16'h8000));
        vec_queue.push_back(pack_vec(16'h7fff, 16'h7fff, 16'h7fff));
        vec_queue.push_back(pack_vec(16'h8000, 16'h7fff, 16'h0001));
        vec_queue.push_back(pack_vec(3, 4, 0));
        vec_queue.push_back(pack_vec(16'hfffd, 0, 16'hfffc));
        vec_queue.push_back(pack_vec(1, 1, 1));
        vec_queue.push_back(pack_vec(16'hffff, 16'hffff, 16'hffff));
        vec_queue.push_back(pack_vec(2, 16'hffff, 16'hfffe));
        for (int i = 0; i < 850; i++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(3))
                    0: v[k] = edges[$urandom_range(6)];
                    1: v[k] = 16'($signed($urandom_range(16)) - 8);
                    default: v[k] = 16'($urandom);
                endcase
            end
            if ($urandom_range(49) == 0) v = '{16'd0, 16'd0, 16'd0};
            vec_queue.push_back(pack_vec(v[0], v[1], v[2]));
            // a burst with no idling on either side
            if (i == 400) begin
                while (vec_queue.size() > 0) @(posedge aclk);
                no_idle = 1'b1;
            end
            if (i == 600) begin
                while (vec_queue.size() > 0) @(posedge aclk);
                no_idle = 1'b0;
            end
        end
        while (vec_queue.size() > 0 || s_tvalid) @(posedge aclk);
        while (unit_queue.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("sent %0d vectors, checked %0d results (%0d zero-length)",
                 n_sent, n_got, n_zero);
        $display("covered edge components, zero vectors, unit extremes and random stalls");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/nv3_pkg.sv
hw/rtl/nv3_prep.sv
hw/rtl/nv3_lane.sv
hw/rtl/nv3_merge.sv
hw/rtl/normalize_vector_3d.sv
test/normalize_vector_3d_tb.sv
